// File: hw/rtl/mmcn_pkg.sv
package mmcn_pkg;

   localparam int COLUMN_DEPTH = 64;
   localparam int ADDR_W       = (COLUMN_DEPTH > 1) ? $clog2(COLUMN_DEPTH) : 1;
   localparam int COUNT_W      = $clog2(COLUMN_DEPTH + 1);
   localparam int SAMPLE_W     = 16;
   localparam int RANGE_W      = 16;
   localparam int FRAC_W       = 16;
   localparam int SCALED_W     = FRAC_W + 1;
   localparam int NUMER_W      = RANGE_W + FRAC_W;
   localparam int STEP_W       = $clog2(SCALED_W);

   localparam logic [STEP_W-1:0] DIV_FIRST_STEP = STEP_W'(SCALED_W - 1);

   typedef struct packed {
      logic load_item;
      logic div_load;
      logic div_step;
      logic next_index;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic degenerate;
      logic div_done;
      logic last_index;
   } dp_status_type;

endpackage

// File: hw/rtl/mmcn_ram.sv
module mmcn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/mmcn_dp.sv
module mmcn_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  mmcn_pkg::dp_cmd_type            cmd,
   input  logic signed [mmcn_pkg::SAMPLE_W-1:0] sample_in,
   output mmcn_pkg::dp_status_type         status,
   output logic [mmcn_pkg::SCALED_W-1:0]   scaled,
   output logic                            degenerate,
   output logic                            overflowed,
   output logic                            end_of_run
);
   import mmcn_pkg::*;

   logic [COUNT_W-1:0]         count_ff, count_in;
   logic [ADDR_W-1:0]          idx_ff, idx_in;
   logic                       overflow_ff, overflow_in;
   logic signed [SAMPLE_W-1:0] min_ff, min_in;
   logic signed [SAMPLE_W-1:0] max_ff, max_in;
   logic [RANGE_W-1:0]         rem_ff, rem_in;
   logic [SCALED_W-1:0]        num_ff, num_in;
   logic [SCALED_W-1:0]        quo_ff, quo_in;
   logic [STEP_W-1:0]          step_ff, step_in;

   logic                       full;
   logic                       wr_en;
   logic [SAMPLE_W-1:0]        rd_data;
   logic [SAMPLE_W:0]          range_diff;
   logic [RANGE_W-1:0]         range_w;
   logic [SAMPLE_W:0]          offset_diff;
   logic [NUMER_W-1:0]         numer;
   logic [RANGE_W:0]           trial;
   logic [RANGE_W:0]           trial_sub;
   logic                       trial_ge;

   assign full  = (count_ff == COUNT_W'(COLUMN_DEPTH));
   assign wr_en = cmd.load_item && !full;

   mmcn_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(COLUMN_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[ADDR_W-1:0]),
      .wr_data(sample_in),
      .rd_addr(idx_ff),
      .rd_data(rd_data)
   );

   assign range_diff  = {max_ff[SAMPLE_W-1], max_ff} - {min_ff[SAMPLE_W-1], min_ff};
   assign range_w     = range_diff[RANGE_W-1:0];
   assign offset_diff = {rd_data[SAMPLE_W-1], rd_data} - {min_ff[SAMPLE_W-1], min_ff};
   assign numer       = {offset_diff[RANGE_W-1:0], {FRAC_W{1'b0}}}
                        + NUMER_W'(range_w >> 1);
   assign trial       = {rem_ff, num_ff[SCALED_W-1]};
   assign trial_sub   = trial - {1'b0, range_w};
   assign trial_ge    = (trial >= {1'b0, range_w});

   always_comb begin
      count_in    = count_ff;
      idx_in      = idx_ff;
      overflow_in = overflow_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      rem_in      = rem_ff;
      num_in      = num_ff;
      quo_in      = quo_ff;
      step_in     = step_ff;
      if (cmd.load_item) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
            if (count_ff == '0) begin
               min_in = sample_in;
               max_in = sample_in;
            end else begin
               if (sample_in < min_ff) min_in = sample_in;
               if (sample_in > max_ff) max_in = sample_in;
            end
         end
      end
      if (cmd.div_load) begin
         rem_in  = RANGE_W'(numer[NUMER_W-1:SCALED_W]);
         num_in  = numer[SCALED_W-1:0];
         quo_in  = '0;
         step_in = DIV_FIRST_STEP;
      end
      if (cmd.div_step) begin
         rem_in  = trial_ge ? trial_sub[RANGE_W-1:0] : trial[RANGE_W-1:0];
         num_in  = {num_ff[SCALED_W-2:0], 1'b0};
         quo_in  = {quo_ff[SCALED_W-2:0], trial_ge};
         step_in = step_ff - 1'b1;
      end
      if (cmd.next_index) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.finish) begin
         count_in    = '0;
         overflow_in = 1'b0;
         idx_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         idx_ff      <= '0;
         overflow_ff <= 1'b0;
         step_ff     <= '0;
      end else begin
         count_ff    <= count_in;
         idx_ff      <= idx_in;
         overflow_ff <= overflow_in;
         step_ff     <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      min_ff <= min_in;
      max_ff <= max_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign status.degenerate = (range_w == '0);
   assign status.div_done   = (step_ff == '0);
   assign status.last_index = ((COUNT_W'(idx_ff) + 1'b1) == count_ff);

   assign scaled     = status.degenerate ? '0 : quo_ff;
   assign degenerate = status.degenerate;
   assign overflowed = overflow_ff;
   assign end_of_run = status.last_index;

endmodule

// File: hw/rtl/mmcn_ctrl.sv
module mmcn_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    final_item,
   input  mmcn_pkg::dp_status_type status,
   output mmcn_pkg::dp_cmd_type    cmd,
   output logic                    busy,
   output logic                    rsp_valid
);
   import mmcn_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_item = 1'b1;
               if (final_item) state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.degenerate) begin
               state_in = ST_EMIT;
            end else begin
               cmd.div_load = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.last_index) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.next_index = 1'b1;
               state_in       = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);

endmodule

// File: hw/rtl/min_max_column_normalizer.sv
// Min-max column normalizer.
// Input words: req_sample (signed) and req_final_item, taken on a clock edge
// with start high and busy low. Samples are stored one per cycle while the
// running minimum and maximum are tracked; up to COLUMN_DEPTH samples are
// kept, later ones are dropped and flag rsp_overflowed on the whole column.
// The word with req_final_item set is stored too and starts emission: busy
// rises and every stored sample comes out in arrival order as
// (x - min) / (max - min), unsigned Q1.16 on rsp_scaled, one word per
// rsp_valid pulse; rsp_end_of_run marks the last one.
// Each result passes through a store read, an operand setup, a restoring
// divider (one quotient bit per cycle) and an output state. A constant
// column skips the divider: rsp_scaled = 0, rsp_degenerate = 1.
// busy falls the cycle after the last result.
// The receiver cannot stall; each result is present for one cycle only.
// Synchronous reset returns to idle with an empty column.
module min_max_column_normalizer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [mmcn_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 req_final_item,
   output logic                                 rsp_valid,
   output logic [mmcn_pkg::SCALED_W-1:0]        rsp_scaled,
   output logic                                 rsp_degenerate,
   output logic                                 rsp_overflowed,
   output logic                                 rsp_end_of_run
);
   import mmcn_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   mmcn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .final_item(req_final_item),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   mmcn_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sample_in (req_sample),
      .status    (status),
      .scaled    (rsp_scaled),
      .degenerate(rsp_degenerate),
      .overflowed(rsp_overflowed),
      .end_of_run(rsp_end_of_run)
   );

   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result outside of busy window");

   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_run |=> !busy)
      else $error("still busy after end of run");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> (rsp_scaled == '0))
      else $error("degenerate result not zero");

   a_scaled_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_scaled <= SCALED_W'(1 << FRAC_W)))
      else $error("scaled value above one");

endmodule
